### rtl/wdc_pkg.sv
// Shared types, constants and glyph table for the watch display controller.
package wdc_pkg;
  localparam logic [1:0] ACT_POLL   = 2'd0;
  localparam logic [1:0] ACT_SECOND = 2'd1;
  localparam logic [1:0] ACT_SCAN   = 2'd2;

  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_TIME    = 2'd1;
  localparam logic [1:0] MODE_BDEB    = 2'd2;
  localparam logic [1:0] MODE_BATT    = 2'd3;

  localparam logic [1:0] CFG_BLINK = 2'd0;
  localparam logic [1:0] CFG_TVIEW = 2'd1;
  localparam logic [1:0] CFG_BVIEW = 2'd2;

  localparam logic [7:0]  DOT_SEG     = 8'h40;
  localparam logic [16:0] DAY_SECONDS = 17'd86400;

  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_TIME = 2'd1;
  localparam logic [1:0] FILL_VOLT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] fill;
  } wdc_cmd_t;

  typedef struct packed {
    logic done;
  } wdc_sts_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0: g = 8'h9f;
      4'd1: g = 8'h84;
      4'd2: g = 8'h2f;
      4'd3: g = 8'had;
      4'd4: g = 8'hb4;
      4'd5: g = 8'hb9;
      4'd6: g = 8'hbb;
      4'd7: g = 8'h8c;
      4'd8: g = 8'hbf;
      4'd9: g = 8'hbd;
      default: g = 8'h00;
    endcase
    return g;
  endfunction
endpackage

### rtl/wdc_digits.sv
// Serial decimal conversion: four digits by repeated subtraction of weights.
module wdc_digits
  import wdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  wdc_cmd_t    cmd,
  input  logic [13:0] value_a,
  input  logic [13:0] value_b,
  output wdc_sts_t    sts,
  output logic [3:0]  dig_o [4]
);
  logic [13:0] rem_r, rem_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  dig_r [4];
  logic [13:0] weight;
  logic [1:0]  fill_r;

  always_comb begin
    unique case (pos_r)
      2'd0: weight = 14'd1000;
      2'd1: weight = 14'd100;
      2'd2: weight = 14'd10;
      default: weight = 14'd1;
    endcase
  end

  always_comb begin
    rem_nxt = rem_r; pos_nxt = pos_r; busy_nxt = busy_r; cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      rem_nxt = (cmd.fill == FILL_TIME) ? value_a : value_b;
      pos_nxt = 2'd0; busy_nxt = 1'b1; cnt_nxt = 4'd0;
    end else if (busy_r) begin
      if (rem_r >= weight && cnt_r != 4'd9) begin
        rem_nxt = rem_r - weight;
        cnt_nxt = cnt_r + 4'd1;
      end else begin
        cnt_nxt = 4'd0;
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd3) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; pos_r <= 2'd0; cnt_r <= 4'd0;
      fill_r <= FILL_NONE;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; pos_r <= pos_nxt; cnt_r <= cnt_nxt;
      if (cmd.start) fill_r <= cmd.fill;
    end
    rem_r <= rem_nxt;
    if (busy_r && !(rem_r >= weight && cnt_r != 4'd9)) dig_r[pos_r] <= cnt_r;
  end

  assign sts.done = done_r && (fill_r != FILL_NONE);
  assign dig_o = dig_r;
endmodule

### rtl/wdc_ctrl.sv
// Controller: event sequencing, mode machine, counters and digit store.
module wdc_ctrl
  import wdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic        button_a,
  input  logic        button_b,
  input  logic        charging,
  input  logic [9:0]  battery_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_data,
  output wdc_cmd_t    cmd,
  input  wdc_sts_t    sts,
  input  logic [3:0]  dig_i [4],
  output logic [13:0] value_a,
  output logic [13:0] value_b
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  st_r;
  logic [9:0]  blink_ticks_r;
  logic [7:0]  tview_r, bview_r;
  logic [1:0]  mode_r;
  logic [16:0] sod_r;
  logic [2:0]  sod_m5_r;
  logic [15:0] blink_r;
  logic [7:0]  tmo_r;
  logic [2:0]  ptr_r;
  logic [7:0]  store_r [5];
  logic        refresh_r, usb_r, scan_r;
  logic [1:0]  fill_r;
  logic        dotchg_r;
  logic [2:0]  dotk_r;
  logic [7:0]  seg_r;
  logic [2:0]  idx_r;
  logic        on_r;
  logic [5:0]  minute_r, hour_r;
  logic [10:0] adc_mv_r;
  logic [15:0] out_data_r;
  logic [20:0] sample_mul;
  logic [31:0] mv_prod;

  // Seconds split into hour and minute kept incrementally.
  logic [5:0] sec_r;
  assign value_a = 14'(hour_r) * 14'd100 + 14'(minute_r);
  assign sample_mul = 21'(battery_sample) * 21'd1100;

  logic [10:0] mv1;
  assign mv1 = sample_mul[20:10];

  // Scale by 43/10: 2254447 = 43 * 52429, and 52429 / 2^19 rounds 1/10 up.
  assign mv_prod = 32'(adc_mv_r) * 32'd2254447;
  assign value_b = {1'b0, mv_prod[31:19]};

  logic [16:0] sod_nxt;
  assign sod_nxt = (sod_r + 17'd1 >= DAY_SECONDS) ? 17'd0 : sod_r + 17'd1;

  assign in_ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    logic [1:0] m;
    logic [1:0] f;
    logic [2:0] p;
    wdc_cmd_t   c;
    if (!rst_n) begin
      st_r <= ST_IDLE; blink_ticks_r <= 10'd150; tview_r <= 8'd5; bview_r <= 8'd2;
      mode_r <= MODE_STANDBY; sod_r <= '0; blink_r <= '0; tmo_r <= '0; ptr_r <= '0;
      for (int i = 0; i < 5; i++) store_r[i] <= 8'h00;
      refresh_r <= 1'b0; usb_r <= 1'b1; scan_r <= 1'b1; out_valid <= 1'b0;
      cmd <= '0; sec_r <= '0; minute_r <= '0; hour_r <= '0; fill_r <= FILL_NONE;
      dotchg_r <= 1'b0; dotk_r <= '0; adc_mv_r <= '0; sod_m5_r <= '0;
      out_data_r <= '0;
    end else begin
      c = '0;
      if (out_valid && out_ready && st_r != ST_OUT) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLINK: blink_ticks_r <= cfg_wdata;
          CFG_TVIEW: tview_r <= cfg_wdata[7:0];
          CFG_BVIEW: bview_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      unique case (st_r)
        ST_IDLE: if (in_valid && in_ready) begin
          seg_r <= 8'h00; idx_r <= 3'd0; on_r <= 1'b0;
          f = FILL_NONE;
          m = mode_r;
          if (action == ACT_POLL) begin
            unique case (mode_r)
              MODE_STANDBY: begin
                for (int i = 0; i < 5; i++) store_r[i] <= 8'h00;
                if (button_a) begin
                  blink_r <= 16'(blink_ticks_r); f = FILL_TIME; m = MODE_TIME;
                  tmo_r <= tview_r;
                end else if (button_b) begin
                  f = FILL_VOLT; m = MODE_BDEB; tmo_r <= bview_r;
                end
              end
              MODE_TIME: if (tmo_r == 8'd0) m = MODE_STANDBY;
              MODE_BDEB: if (!button_b) m = MODE_BATT;
              default: begin
                if (button_b) begin
                  usb_r <= ~usb_r; f = FILL_VOLT; m = MODE_BDEB; tmo_r <= bview_r;
                end
                if (tmo_r == 8'd0 && !button_b) m = MODE_STANDBY;
                if (button_b && bview_r == 8'd0) m = MODE_STANDBY;
              end
            endcase
            mode_r <= m;
            if (m != MODE_STANDBY || charging) begin
              refresh_r <= 1'b1; scan_r <= 1'b1;
            end else refresh_r <= 1'b0;
            dotchg_r <= (m == MODE_STANDBY) && charging;
            dotk_r <= sod_m5_r;
            adc_mv_r <= mv1;
          end else if (action == ACT_SECOND) begin
            sod_r <= sod_nxt;
            sod_m5_r <= (sod_nxt == 17'd0 || sod_m5_r == 3'd4) ? 3'd0 : sod_m5_r + 3'd1;
            if (sod_nxt == 17'd0) begin
              sec_r <= '0; minute_r <= '0; hour_r <= '0;
            end else if (sec_r == 6'd59) begin
              sec_r <= '0;
              if (minute_r == 6'd59) begin
                minute_r <= '0; hour_r <= hour_r + 6'd1;
              end else minute_r <= minute_r + 6'd1;
            end else sec_r <= sec_r + 6'd1;
            blink_r <= '0;
            if (tmo_r != 8'd0) tmo_r <= tmo_r - 8'd1;
            if (mode_r == MODE_TIME) f = FILL_TIME;
            dotchg_r <= 1'b0;
          end else if (action == ACT_SCAN && scan_r) begin
            p = (ptr_r >= 3'd5) ? 3'd0 : ptr_r;
            idx_r <= p; on_r <= 1'b1; seg_r <= store_r[p];
            if (mode_r == MODE_TIME) begin
              blink_r <= blink_r + 16'd1;
              store_r[4] <= (blink_r < 16'(blink_ticks_r)) ? 8'hff : 8'h00;
            end
            if (!refresh_r && p == 3'd4) begin
              seg_r <= 8'h00; scan_r <= 1'b0;
            end
            ptr_r <= (p == 3'd4) ? 3'd0 : p + 3'd1;
          end
          fill_r <= f;
          if (f != FILL_NONE) begin
            c.start = 1'b1; c.fill = f; st_r <= ST_CONV;
          end else st_r <= ST_OUT;
        end
        ST_CONV: if (sts.done) begin
          store_r[0] <= glyph(dig_i[0]) | ((fill_r == FILL_VOLT) ? DOT_SEG : 8'h00);
          store_r[1] <= glyph(dig_i[1]);
          store_r[2] <= glyph(dig_i[2]);
          store_r[3] <= glyph(dig_i[3]) |
                        ((fill_r == FILL_VOLT && usb_r) ? DOT_SEG : 8'h00);
          st_r <= ST_OUT;
        end
        default: if (!out_valid || out_ready) begin
          if (dotchg_r) begin
            for (int i = 0; i < 4; i++)
              if (3'(i) < dotk_r) store_r[i] <= DOT_SEG;
          end
          dotchg_r <= 1'b0;
          out_data_r <= {scan_r, usb_r, mode_r, on_r, idx_r, seg_r};
          out_valid <= 1'b1;
          st_r <= ST_IDLE;
        end
      endcase
      cmd <= c;
    end
  end

  assign out_data = out_data_r;

`ifndef NO_ASSERTIONS
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> st_r == ST_CONV) else $error("start outside conversion");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ready) else $error("accept while busy");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= 3'd4) else $error("pointer out of range");
`endif
endmodule

### rtl/watch_display_controller_core.sv
// out_tvalid rises from ST_OUT once the output register is free; an event that refills the
// four display digits from a decimal value first waits in ST_CONV until wdc_digits is done.
// Only one event is in flight; the next is taken once ST_IDLE is re-entered as out_tvalid rises.
// wdc_digits subtracts one decimal weight per cycle; a result held in the output stalls the next.
// Reset: synchronous active-low rst_n loads the register defaults, standby mode,
// USB flag and scan enable set, digit store cleared.
module watch_display_controller_core
  import wdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,  // action
  input  logic [15:0] in_tdata,  // button_a, button_b, charging, battery_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // segments, digit_index, digit_on, mode, usb_mode, scan_running
);
  wdc_cmd_t    cmd;
  wdc_sts_t    sts;
  logic [3:0]  dig [4];
  logic [13:0] va, vb;

  wdc_digits u_dig (.clk, .rst_n, .cmd, .value_a(va), .value_b(vb), .sts, .dig_o(dig));

  wdc_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid(in_tvalid), .in_ready(in_tready), .action(in_tuser),
    .button_a(in_tdata[0]), .button_b(in_tdata[1]), .charging(in_tdata[2]),
    .battery_sample(in_tdata[12:3]),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .cmd, .sts, .dig_i(dig), .value_a(va), .value_b(vb)
  );
endmodule

### sim/watch_display_controller_core_tb.sv
// Self-checking testbench for the watch display controller core: random events against a predictor.
module watch_display_controller_core_tb
  import wdc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] action;
    logic       button_a;
    logic       button_b;
    logic       charging;
    logic [9:0] sample;
  } event_t;

  typedef struct packed {
    logic       scan_running;
    logic       usb_mode;
    logic [1:0] mode;
    logic       digit_on;
    logic [2:0] digit_index;
    logic [7:0] segments;
  } view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BLINK;
  logic [9:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;

  watch_display_controller_core dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [9:0]  blink_ticks;
  logic [7:0]  tview_secs, bview_secs;
  logic [1:0]  view_mode;
  logic [16:0] sec_of_day;
  logic [15:0] blink_cnt;
  logic [7:0]  timeout_left;
  logic [2:0]  scan_ptr;
  logic [7:0]  digits [5];
  logic        refresh_wanted, usb_flag, scan_en;

  event_t pending_events[$];
  view_t  expected_views[$];
  int errors = 0;
  int beats_sent = 0, beats_seen = 0, scans_seen = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  int hold_cycles = 0;
  int gap_cycles = 0;
  int long_hold = 0;
  bit long_hold_go = 1'b0;
  bit long_hold_done = 1'b0;

  function automatic logic [7:0] seg_of(int d);
    case (d)
      0: return 8'h9f; 1: return 8'h84; 2: return 8'h2f; 3: return 8'had;
      4: return 8'hb4; 5: return 8'hb9; 6: return 8'hbb; 7: return 8'h8c;
      8: return 8'hbf; default: return 8'hbd;
    endcase
  endfunction

  function automatic void draw_clock();
    int mi, hr;
    mi = (sec_of_day / 60) % 60;
    hr = (sec_of_day / 3600) % 24;
    digits[0] = seg_of(hr / 10);
    digits[1] = seg_of(hr % 10);
    digits[2] = seg_of(mi / 10);
    digits[3] = seg_of(mi % 10);
  endfunction

  function automatic void show_volts(logic [9:0] s);
    int mv;
    mv = (int'(s) * 1100 / 1024) * 43 / 10;
    digits[0] = seg_of((mv / 1000) % 10) | DOT_SEG;
    digits[1] = seg_of((mv / 100) % 10);
    digits[2] = seg_of((mv / 10) % 10);
    digits[3] = seg_of(mv % 10);
    if (usb_flag) digits[3] = digits[3] | DOT_SEG;
  endfunction

  function automatic void reset_model();
    blink_ticks = 10'd150; tview_secs = 8'd5; bview_secs = 8'd2;
    view_mode = MODE_STANDBY; sec_of_day = '0; blink_cnt = '0;
    timeout_left = '0; scan_ptr = '0;
    for (int i = 0; i < 5; i++) digits[i] = '0;
    refresh_wanted = 1'b0; usb_flag = 1'b1; scan_en = 1'b1;
  endfunction

  function automatic void do_poll(event_t e);
    int k;
    case (view_mode)
      MODE_STANDBY: begin
        for (int i = 0; i < 5; i++) digits[i] = '0;
        if (e.button_a) begin
          blink_cnt = 16'(blink_ticks);
          draw_clock();
          view_mode = MODE_TIME;
          timeout_left = tview_secs;
        end else if (e.button_b) begin
          show_volts(e.sample);
          view_mode = MODE_BDEB;
          timeout_left = bview_secs;
        end
      end
      MODE_TIME: if (timeout_left == 0) view_mode = MODE_STANDBY;
      MODE_BDEB: if (!e.button_b) view_mode = MODE_BATT;
      default: begin
        if (e.button_b) begin
          usb_flag = ~usb_flag;
          show_volts(e.sample);
          view_mode = MODE_BDEB;
          timeout_left = bview_secs;
        end
        if (timeout_left == 0) view_mode = MODE_STANDBY;
      end
    endcase
    if (view_mode != MODE_STANDBY || e.charging) begin
      refresh_wanted = 1'b1; scan_en = 1'b1;
    end else begin
      refresh_wanted = 1'b0;
    end
    if (view_mode == MODE_STANDBY && e.charging) begin
      k = sec_of_day % 5;
      for (int i = 0; i < k && i < 4; i++) digits[i] = DOT_SEG;
    end
  endfunction

  function automatic view_t predict_view(event_t e);
    view_t v;
    logic [2:0] p;
    v = '0;
    if (e.action == ACT_POLL) begin
      do_poll(e);
    end else if (e.action == ACT_SECOND) begin
      sec_of_day = (sec_of_day + 1 >= DAY_SECONDS) ? '0 : sec_of_day + 1;
      blink_cnt = '0;
      if (timeout_left != 0) timeout_left--;
      if (view_mode == MODE_TIME) draw_clock();
    end else if (e.action == ACT_SCAN && scan_en) begin
      p = (scan_ptr >= 5) ? 3'd0 : scan_ptr;
      v.digit_index = p;
      v.digit_on = 1'b1;
      v.segments = digits[p];
      if (view_mode == MODE_TIME) begin
        digits[4] = (blink_cnt < 16'(blink_ticks)) ? 8'hff : 8'h00;
        blink_cnt = blink_cnt + 1;
      end
      if (!refresh_wanted && p == 3'd4) begin
        v.segments = '0; scan_en = 1'b0;
      end
      scan_ptr = (p + 1) % 5;
    end
    v.mode = view_mode;
    v.usb_mode = usb_flag;
    v.scan_running = scan_en;
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    event_t e;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_views.push_back(predict_view(pending_events.pop_front()));
        beats_sent <= beats_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_cycles > 0) begin
          gap_cycles <= gap_cycles - 1;
          in_tvalid <= 1'b0;
        end else if ((in_tvalid && in_tready ? pending_events.size() > 0
                      : pending_events.size() > 0) && !(in_tvalid && in_tready
                      && pending_events.size() == 0)) begin
          e = pending_events[0];
          if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_cycles <= $urandom_range(1, 9) - 1;
            in_tvalid <= 1'b0;
          end else begin
            in_tvalid <= 1'b1;
            in_tuser <= e.action;
            in_tdata <= {3'b0, e.sample, e.charging, e.button_b, e.button_a};
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold <= 300;
      long_hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    view_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = view_t'(out_tdata);
        beats_seen <= beats_seen + 1;
        if (got.digit_on) scans_seen <= scans_seen + 1;
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_views.pop_front();
          if (got.segments !== want.segments)
            $display("%0t: segments expected %h actual %h", $time, want.segments, got.segments);
          if (got.digit_index !== want.digit_index)
            $display("%0t: digit_index expected %0d actual %0d", $time,
                     want.digit_index, got.digit_index);
          if (got.digit_on !== want.digit_on)
            $display("%0t: digit_on expected %0d actual %0d", $time, want.digit_on, got.digit_on);
          if (got.mode !== want.mode)
            $display("%0t: mode expected %0d actual %0d", $time, want.mode, got.mode);
          if (got.usb_mode !== want.usb_mode)
            $display("%0t: usb_mode expected %0d actual %0d", $time, want.usb_mode, got.usb_mode);
          if (got.scan_running !== want.scan_running)
            $display("%0t: scan_running expected %0d actual %0d", $time,
                     want.scan_running, got.scan_running);
          if (got !== want) errors++;
        end
      end
      if (long_hold > 0) begin
        out_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold_cycles <= $urandom_range(1, 9) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 64'd2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic event_t mk(logic [1:0] a, logic ba, logic bb, logic ch, logic [9:0] s);
    event_t e;
    e.action = a; e.button_a = ba; e.button_b = bb; e.charging = ch; e.sample = s;
    return e;
  endfunction

  function automatic event_t rand_event();
    return mk(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom),
              10'($urandom));
  endfunction

  task automatic add_scans(int n);
    for (int i = 0; i < n; i++) pending_events.push_back(mk(ACT_SCAN, 0, 0, 0, 0));
  endtask

  // a plausible stretch of watch use with random content
  task automatic add_session();
    int r;
    r = $urandom_range(0, 4);
    case (r)
      0: pending_events.push_back(mk(ACT_POLL, 1, 0, 1'($urandom), 10'($urandom)));
      1: begin
        pending_events.push_back(mk(ACT_POLL, 0, 1, 1'($urandom), 10'($urandom)));
        pending_events.push_back(mk(ACT_POLL, 0, 0, 1'($urandom), 10'($urandom)));
        pending_events.push_back(mk(ACT_POLL, 0, 1, 1'($urandom), 10'($urandom)));
      end
      2: pending_events.push_back(mk(ACT_POLL, 0, 0, 1'($urandom), 10'($urandom)));
      3: for (int i = 0; i < 3; i++) pending_events.push_back(mk(ACT_SECOND, 0, 0, 0, 0));
      default: pending_events.push_back(rand_event());
    endcase
    add_scans($urandom_range(2, 12));
    if ($urandom_range(0, 2) == 0) pending_events.push_back(mk(ACT_SECOND, 0, 0, 0, 0));
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || expected_views.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BLINK: blink_ticks = val;
      CFG_TVIEW: tview_secs = val[7:0];
      default:   bview_secs = val[7:0];
    endcase
    @(posedge clk);
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: scan stop, time view, battery view, usb toggle, charging, unknown action
    add_scans(6);
    pending_events.push_back(mk(ACT_POLL, 1, 0, 0, 10'd0));
    add_scans(6);
    pending_events.push_back(mk(ACT_SECOND, 0, 0, 0, 0));
    add_scans(5);
    pending_events.push_back(mk(ACT_POLL, 0, 0, 1, 10'd1023));
    pending_events.push_back(mk(2'd3, 1, 1, 1, 10'h3ff));
    drain();
    write_reg(CFG_BLINK, 10'd0);
    write_reg(CFG_TVIEW, 10'd0);
    write_reg(CFG_BVIEW, 10'd255);
    pending_events.push_back(mk(ACT_POLL, 0, 0, 0, 10'd0));
    pending_events.push_back(mk(ACT_POLL, 0, 1, 0, 10'd1023));
    pending_events.push_back(mk(ACT_POLL, 0, 0, 0, 10'd512));
    pending_events.push_back(mk(ACT_POLL, 0, 1, 0, 10'd0));
    add_scans(5);
    pending_events.push_back(mk(ACT_POLL, 1, 1, 1, 10'h155));
    // long receiver stall while events keep coming
    while (!out_tvalid) @(posedge clk);
    long_hold_go = 1'b1;
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(CFG_BLINK, 10'd1023); write_reg(CFG_TVIEW, 10'd255);
                 write_reg(CFG_BVIEW, 10'd0); end
        1: begin write_reg(CFG_BLINK, 10'd3); write_reg(CFG_TVIEW, 10'd2);
                 write_reg(CFG_BVIEW, 10'd1); end
        2: begin write_reg(CFG_BLINK, 10'($urandom)); write_reg(CFG_TVIEW, 10'($urandom_range(0, 8)));
                 write_reg(CFG_BVIEW, 10'($urandom_range(0, 8))); end
        default: begin write_reg(CFG_BLINK, 10'd150); write_reg(CFG_TVIEW, 10'd5);
                       write_reg(CFG_BVIEW, 10'd2); quiet = 1'b1; end
      endcase
      for (int n = 0; n < 23; n++) add_session();
      for (int n = 0; n < 20; n++) pending_events.push_back(rand_event());
      drain();
    end
    write_reg(CFG_TVIEW, 10'd255);
    pending_events.push_back(mk(ACT_POLL, 1, 0, 0, 0));
    drain();
    $display("Covered view changes, scan stops, USB toggles and charging dots under stalls.");
    $display("%0d beats sent, %0d checked, %0d driven digits, register settings at both ends.",
             beats_sent, beats_seen, scans_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
